// File: rtl/core/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Types and constants shared by the message route decision core.
// ----------------------------------------------------------------------------
package mrd_pkg;

    // Ingress port of a message header
    typedef enum logic [1:0] {
        FUNC_SUBSYS = 2'd0,
        FUNC_NODE   = 2'd1,
        FUNC_CMPT   = 2'd2,
        FUNC_COMM   = 2'd3
    } t_func;

    // Drop rules, in the order they are tested
    typedef enum logic [3:0] {
        ERR_NONE              = 4'd0,
        ERR_SS_SRC_OWN        = 4'd1,
        ERR_SS_DST_FOREIGN    = 4'd2,
        ERR_ND_SRC_SELF       = 4'd3,
        ERR_ND_DST_OTHER_NODE = 4'd4,
        ERR_ND_DST_NODE_MISS  = 4'd5,
        ERR_ND_DST_FOREIGN    = 4'd6,
        ERR_CP_SRC_SS         = 4'd7,
        ERR_CP_SRC_NODE       = 4'd8,
        ERR_CP_DST_SELF       = 4'd9,
        ERR_CM_SRC_SS         = 4'd10,
        ERR_CM_DST_OWN        = 4'd11,
        ERR_CM_NO_ROUTE       = 4'd12
    } t_err;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_SS    = 3'd0,
        CFG_OWN_NODE  = 3'd1,
        CFG_SS_LINK   = 3'd2,
        CFG_BCAST_SS  = 3'd3,
        CFG_BCAST_ND  = 3'd4,
        CFG_PRIMARY   = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_OWN_SS   = 8'd1;
    localparam logic [7:0] RST_OWN_NODE = 8'd1;
    localparam logic       RST_SS_LINK  = 1'b0;
    localparam logic [7:0] RST_BCAST_SS = 8'd255;
    localparam logic [7:0] RST_BCAST_ND = 8'd255;
    localparam logic [7:0] RST_PRIMARY  = 8'd1;

    // Configuration as seen by the decision logic
    typedef struct packed {
        logic [7:0] own_subsystem_id;
        logic [7:0] own_node_id;
        logic       subsystem_link_enabled;
        logic [7:0] broadcast_subsystem_id;
        logic [7:0] broadcast_node_id;
        logic [7:0] primary_node_id;
    } t_cfg;

    // One message header
    typedef struct packed {
        t_func      func;
        logic [7:0] src_subsystem;
        logic [7:0] src_node;
        logic [7:0] dst_subsystem;
        logic [7:0] dst_node;
        logic       comm_found;
        logic [7:0] comm_node;
    } t_req;

    // One routing decision
    typedef struct packed {
        logic to_subsystem_link;
        logic to_node_link;
        logic to_component_link;
        logic accepted;
        t_err error_code;
    } t_rsp;

endpackage

// File: rtl/core/mrd_req_if.sv
// ----------------------------------------------------------------------------
// mrd_req_if
// Header channel into the route decision core: valid, ready and payload.
// ----------------------------------------------------------------------------
interface mrd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] src_subsystem;
    logic [7:0] src_node;
    logic [7:0] dst_subsystem;
    logic [7:0] dst_node;
    logic       comm_found;
    logic [7:0] comm_node;

    modport source (
        output valid, func, src_subsystem, src_node, dst_subsystem, dst_node,
               comm_found, comm_node,
        input  ready
    );

    modport sink (
        input  valid, func, src_subsystem, src_node, dst_subsystem, dst_node,
               comm_found, comm_node,
        output ready
    );
endinterface

// File: rtl/core/mrd_rsp_if.sv
// ----------------------------------------------------------------------------
// mrd_rsp_if
// Decision channel out of the route decision core: valid, ready and payload.
// ----------------------------------------------------------------------------
interface mrd_rsp_if;
    logic       valid;
    logic       ready;
    logic       to_subsystem_link;
    logic       to_node_link;
    logic       to_component_link;
    logic       accepted;
    logic [3:0] error_code;

    modport source (
        output valid, to_subsystem_link, to_node_link, to_component_link,
               accepted, error_code,
        input  ready
    );

    modport sink (
        input  valid, to_subsystem_link, to_node_link, to_component_link,
               accepted, error_code,
        output ready
    );
endinterface

// File: rtl/core/message_route_decision_core.sv
// ----------------------------------------------------------------------------
// message_route_decision_core: egress links, accept flag and error per header.
// A header passes through the input register and then the result register to the decision output.
// Throughput one header per cycle unless the decision channel stalls; one combinational compare pass lies between them.
// Synchronous active-low reset empties both stages and restores the default IDs.
// ----------------------------------------------------------------------------
module message_route_decision_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mrd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mrd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    mrd_req_if.sink                       i_req,
    mrd_rsp_if.source                     o_rsp
);

    mrd_pkg::t_cfg cfg;
    mrd_pkg::t_req req_in;
    mrd_pkg::t_rsp rsp_next;

    logic          r_req_vld;
    mrd_pkg::t_req r_req;
    logic          r_rsp_vld;
    mrd_pkg::t_rsp r_rsp;

    logic          out_rdy;
    logic          in_rdy;

    // Configuration registers
    mrd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Gather the header payload
    assign req_in.func          = mrd_pkg::t_func'(i_req.func);
    assign req_in.src_subsystem = i_req.src_subsystem;
    assign req_in.src_node      = i_req.src_node;
    assign req_in.dst_subsystem = i_req.dst_subsystem;
    assign req_in.dst_node      = i_req.dst_node;
    assign req_in.comm_found    = i_req.comm_found;
    assign req_in.comm_node     = i_req.comm_node;

    // Each stage advances when the one after it is empty or being drained
    assign out_rdy     = !r_rsp_vld || o_rsp.ready;
    assign in_rdy      = !r_req_vld || out_rdy;
    assign i_req.ready = in_rdy;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (in_rdy) begin
            r_req_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_req.valid) begin
            r_req <= req_in;
        end
    end

    // Decision logic
    mrd_decide u_decide (
        .i_cfg (cfg),
        .i_req (r_req),
        .o_rsp (rsp_next)
    );

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (out_rdy) begin
            r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_req_vld) begin
            r_rsp <= rsp_next;
        end
    end

    // Drive the decision channel
    assign o_rsp.valid             = r_rsp_vld;
    assign o_rsp.to_subsystem_link = r_rsp.to_subsystem_link;
    assign o_rsp.to_node_link      = r_rsp.to_node_link;
    assign o_rsp.to_component_link = r_rsp.to_component_link;
    assign o_rsp.accepted          = r_rsp.accepted;
    assign o_rsp.error_code        = r_rsp.error_code;

`ifndef SYNTHESIS
    // A dropped header goes nowhere and names its rule
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld && !r_rsp.accepted |->
            !r_rsp.to_subsystem_link && !r_rsp.to_node_link &&
            !r_rsp.to_component_link && (r_rsp.error_code != mrd_pkg::ERR_NONE))
        else $error("dropped header with link set or no error code");

    // Only a failed communicator forward may be accepted with an error
    a_accept_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld && r_rsp.accepted && (r_rsp.error_code != mrd_pkg::ERR_NONE) |->
            (r_rsp.error_code == mrd_pkg::ERR_CM_SRC_SS) ||
            (r_rsp.error_code == mrd_pkg::ERR_CM_DST_OWN) ||
            (r_rsp.error_code == mrd_pkg::ERR_CM_NO_ROUTE))
        else $error("accepted header carries an unexpected error code");

    // A transferred header lands in the input register
    a_req_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && in_rdy |=> r_req_vld)
        else $error("transferred header lost at input register");

    // A stalled decision holds in the result register
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld && !o_rsp.ready |=> r_rsp_vld && $stable(r_rsp))
        else $error("stalled decision changed or vanished");

    // A full input stage with a free result stage moves on
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_vld && out_rdy |=> r_rsp_vld)
        else $error("header did not advance into result register");
`endif

endmodule

// File: rtl/core/mrd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrd_cfg_regs
// Configuration register file: own, broadcast and primary IDs and link enable.
// ----------------------------------------------------------------------------
module mrd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mrd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mrd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output mrd_pkg::t_cfg                 o_cfg
);

    mrd_pkg::t_cfg r_cfg;
    mrd_pkg::t_cfg n_cfg;

    // Decode the write; unknown indexes leave everything untouched
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (mrd_pkg::t_cfg_idx'(i_cfg_idx))
                mrd_pkg::CFG_OWN_SS:   n_cfg.own_subsystem_id       = i_cfg_data;
                mrd_pkg::CFG_OWN_NODE: n_cfg.own_node_id            = i_cfg_data;
                mrd_pkg::CFG_SS_LINK:  n_cfg.subsystem_link_enabled = i_cfg_data[0];
                mrd_pkg::CFG_BCAST_SS: n_cfg.broadcast_subsystem_id = i_cfg_data;
                mrd_pkg::CFG_BCAST_ND: n_cfg.broadcast_node_id      = i_cfg_data;
                mrd_pkg::CFG_PRIMARY:  n_cfg.primary_node_id        = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the registers, load reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_subsystem_id       <= mrd_pkg::RST_OWN_SS;
            r_cfg.own_node_id            <= mrd_pkg::RST_OWN_NODE;
            r_cfg.subsystem_link_enabled <= mrd_pkg::RST_SS_LINK;
            r_cfg.broadcast_subsystem_id <= mrd_pkg::RST_BCAST_SS;
            r_cfg.broadcast_node_id      <= mrd_pkg::RST_BCAST_ND;
            r_cfg.primary_node_id        <= mrd_pkg::RST_PRIMARY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/mrd_decide.sv
// ----------------------------------------------------------------------------
// mrd_decide
// Combinational route decision for one registered header.
// ----------------------------------------------------------------------------
module mrd_decide (
    input  mrd_pkg::t_cfg i_cfg,
    input  mrd_pkg::t_req i_req,
    output mrd_pkg::t_rsp o_rsp
);

    // Address compares, shared by the ingress paths
    logic ss_own;
    logic sn_own;
    logic ds_own;
    logic ds_bcast;
    logic dn_own;
    logic dn_bcast;
    logic dn_here;

    assign ss_own   = (i_req.src_subsystem == i_cfg.own_subsystem_id);
    assign sn_own   = (i_req.src_node      == i_cfg.own_node_id);
    assign ds_own   = (i_req.dst_subsystem == i_cfg.own_subsystem_id);
    assign ds_bcast = (i_req.dst_subsystem == i_cfg.broadcast_subsystem_id);
    assign dn_own   = (i_req.dst_node      == i_cfg.own_node_id);
    assign dn_bcast = (i_req.dst_node      == i_cfg.broadcast_node_id);
    assign dn_here  = dn_bcast || dn_own;

    // Forward towards the communicator of the own subsystem
    mrd_pkg::t_rsp comm;

    always_comb begin
        comm = '{default: '0, error_code: mrd_pkg::ERR_NONE};
        if (!ss_own) begin
            comm.error_code = mrd_pkg::ERR_CM_SRC_SS;
        end else if (ds_own) begin
            comm.error_code = mrd_pkg::ERR_CM_DST_OWN;
        end else if (i_cfg.subsystem_link_enabled) begin
            comm.to_subsystem_link = 1'b1;
            comm.to_node_link      = ds_bcast && !dn_own;
            comm.accepted          = 1'b1;
        end else if (!i_req.comm_found || (i_req.comm_node == i_cfg.own_node_id) ||
                     (i_cfg.own_node_id == i_cfg.primary_node_id)) begin
            comm.error_code = mrd_pkg::ERR_CM_NO_ROUTE;
        end else begin
            comm.to_node_link = 1'b1;
            comm.accepted     = 1'b1;
        end
    end

    // Select the rule set of the ingress port
    always_comb begin
        o_rsp = '{default: '0, error_code: mrd_pkg::ERR_NONE};
        unique case (i_req.func)
            mrd_pkg::FUNC_SUBSYS: begin
                if (ss_own) begin
                    o_rsp.error_code = mrd_pkg::ERR_SS_SRC_OWN;
                end else if (!ds_own && !ds_bcast) begin
                    o_rsp.error_code = mrd_pkg::ERR_SS_DST_FOREIGN;
                end else begin
                    o_rsp.accepted          = 1'b1;
                    o_rsp.to_node_link      = dn_bcast || !dn_own;
                    o_rsp.to_component_link = dn_bcast || dn_own;
                end
            end
            mrd_pkg::FUNC_NODE: begin
                if (ss_own) begin
                    if (sn_own) begin
                        o_rsp.error_code = mrd_pkg::ERR_ND_SRC_SELF;
                    end else if (ds_bcast) begin
                        o_rsp.accepted          = 1'b1;
                        o_rsp.to_subsystem_link = 1'b1;
                        o_rsp.to_component_link = dn_here;
                    end else if (ds_own) begin
                        if (dn_here) begin
                            o_rsp.accepted          = 1'b1;
                            o_rsp.to_component_link = 1'b1;
                        end else begin
                            o_rsp.error_code = mrd_pkg::ERR_ND_DST_OTHER_NODE;
                        end
                    end else begin
                        o_rsp.accepted          = 1'b1;
                        o_rsp.to_subsystem_link = 1'b1;
                    end
                end else if (ds_bcast || ds_own) begin
                    if (dn_here) begin
                        o_rsp.accepted          = 1'b1;
                        o_rsp.to_component_link = 1'b1;
                    end else begin
                        o_rsp.error_code = mrd_pkg::ERR_ND_DST_NODE_MISS;
                    end
                end else begin
                    o_rsp.error_code = mrd_pkg::ERR_ND_DST_FOREIGN;
                end
            end
            mrd_pkg::FUNC_CMPT: begin
                if (!ss_own) begin
                    o_rsp.error_code = mrd_pkg::ERR_CP_SRC_SS;
                end else if (!sn_own) begin
                    o_rsp.error_code = mrd_pkg::ERR_CP_SRC_NODE;
                end else if (ds_own) begin
                    if (dn_own) begin
                        o_rsp.error_code = mrd_pkg::ERR_CP_DST_SELF;
                    end else begin
                        o_rsp.accepted     = 1'b1;
                        o_rsp.to_node_link = 1'b1;
                    end
                end else begin
                    // A component forward counts as accepted even when it fails
                    o_rsp          = comm;
                    o_rsp.accepted = 1'b1;
                end
            end
            mrd_pkg::FUNC_COMM: begin
                o_rsp = comm;
            end
            default: ;
        endcase
    end

endmodule
